/* rtl/drt_pkg.sv */
// Package for the disk region table engine: word types, command and status codes, FSM states.
`timescale 1ns / 1ps

package drt_pkg;

	localparam logic [2:0] CMD_ADD    = 3'd0;
	localparam logic [2:0] CMD_REMOVE = 3'd1;
	localparam logic [2:0] CMD_GET    = 3'd2;
	localparam logic [2:0] CMD_FREE   = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_FULL    = 2'd1;
	localparam logic [1:0] STAT_OVERLAP = 2'd2;
	localparam logic [1:0] STAT_RANGE   = 2'd3;

	localparam logic [31:0] FIRST_USABLE_RESET = 32'd2048;
	localparam logic [31:0] ALL_ONES           = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] region_base;
		logic [31:0] region_len;
		logic [7:0]  region_kind;
		logic [3:0]  entry_index;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  entry_count;
		logic [31:0] entry_start;
		logic [31:0] entry_size;
		logic [7:0]  entry_type;
		logic [31:0] free_start;
		logic [31:0] free_size;
	} rsp_t;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] size;
		logic [7:0]  ptype;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD_SCAN,
		S_REM_SHIFT,
		S_GET_WAIT,
		S_FREE_SCAN
	} fsm_state_t;

endpackage

/* rtl/drt_region_mem.sv */
// Region table memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module drt_region_mem
	import drt_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data
);

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/disk_region_table_engine.sv */
// Top level of the disk region table engine: command sequencer around the region memory.
//
//   channel   direction  handshake               word
//   command   in         start / busy            cmd    (cmd_t)
//   result    out        done (one-cycle strobe) result (rsp_t)
//   config    in         cfg_valid / cfg_ready   cfg_data (first usable block)
//
// A command is taken when start is high and busy is low; its result follows as a one-cycle
// done strobe. Clear, unused codes, refused commands, remove of the last entry and add or
// free space on an empty table answer in the cycle after acceptance; get answers from
// its wait state, with the registered memory read data. Add and free space walk the
// stored regions through the memory read port, one per cycle, and add stops early when
// it meets an overlap. Remove moves every later entry down one slot per cycle. The worst
// case is a free-space search over a full table; busy is low while done is shown, so
// the next command can be taken in that cycle.
// Reset clears the entry count and the sequencer; the memory needs no clearing pass.
// The receiver cannot stall; cfg_ready is always high.
`timescale 1ns / 1ps

module disk_region_table_engine
	import drt_pkg::*;
#(
	parameter int MAX_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cmd_t        cmd,
	output logic        done,
	output rsp_t        result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (CNT_W > 4) ? CNT_W + 1 : 5;

	fsm_state_t state_q, state_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [CNT_W-1:0] count_q, count_d;
	cmd_t cmd_q, cmd_d;
	logic [31:0] highest_q, highest_d;
	logic [31:0] first_usable_q;
	logic done_q, done_d;
	rsp_t result_q, result_d;

	logic wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	entry_t wr_data, rd_data;

	logic [31:0] new_end, cur_end, max_end;
	logic scan_last, overlap, idx_in_range, rem_more_in, rem_more;
	logic [CNT_W-1:0] ptr_plus1;
	logic [CMP_W-1:0] idx_plus1;
	logic [CNT_W:0] ptr_plus2;

	drt_region_mem #(
		.DEPTH(MAX_ENTRIES),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Free space above the highest end; nothing is left when that end is all-ones.
	function automatic rsp_t free_result(input logic [31:0] h);
		rsp_t r;
		r = '0;
		if (h != ALL_ONES) begin
			r.free_start = h;
			r.free_size = ALL_ONES - h;
		end
		return r;
	endfunction

	assign new_end = cmd_q.region_base + cmd_q.region_len;
	assign cur_end = rd_data.start + rd_data.size;
	assign overlap = (cmd_q.region_base < cur_end) && (new_end > rd_data.start);
	assign max_end = (cur_end > highest_q) ? cur_end : highest_q;
	assign ptr_plus1 = CNT_W'(ptr_q) + CNT_W'(1);
	assign ptr_plus2 = (CNT_W + 1)'(ptr_q) + (CNT_W + 1)'(2);
	assign scan_last = (ptr_plus1 == count_q);
	assign rem_more = (ptr_plus2 < (CNT_W + 1)'(count_q));
	assign idx_plus1 = CMP_W'(cmd.entry_index) + CMP_W'(1);
	assign idx_in_range = (CMP_W'(cmd.entry_index) < CMP_W'(count_q));
	assign rem_more_in = (idx_plus1 < CMP_W'(count_q));

	always_comb begin
		state_d = state_q;
		ptr_d = ptr_q;
		count_d = count_q;
		cmd_d = cmd_q;
		highest_d = highest_q;
		done_d = 1'b0;
		result_d = '0;
		wr_en = 1'b0;
		wr_addr = ptr_q;
		wr_data = rd_data;
		rd_en = 1'b0;
		rd_addr = AW'(ptr_plus1);

		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_d = cmd;
					ptr_d = '0;
					case (cmd.command)
						CMD_ADD: begin
							if (count_q >= CNT_W'(MAX_ENTRIES)) begin
								done_d = 1'b1;
								result_d.status = STAT_FULL;
							end else if (count_q == '0) begin
								wr_en = 1'b1;
								wr_addr = '0;
								wr_data = '{start: cmd.region_base, size: cmd.region_len,
									ptype: cmd.region_kind};
								count_d = CNT_W'(1);
								done_d = 1'b1;
							end else begin
								rd_en = 1'b1;
								rd_addr = '0;
								state_d = S_ADD_SCAN;
							end
						end
						CMD_REMOVE: begin
							if (!idx_in_range) begin
								done_d = 1'b1;
								result_d.status = STAT_RANGE;
							end else if (rem_more_in) begin
								ptr_d = AW'(cmd.entry_index);
								rd_en = 1'b1;
								rd_addr = AW'(idx_plus1);
								state_d = S_REM_SHIFT;
							end else begin
								count_d = count_q - CNT_W'(1);
								done_d = 1'b1;
							end
						end
						CMD_GET: begin
							if (!idx_in_range) begin
								done_d = 1'b1;
								result_d.status = STAT_RANGE;
							end else begin
								rd_en = 1'b1;
								rd_addr = AW'(cmd.entry_index);
								state_d = S_GET_WAIT;
							end
						end
						CMD_FREE: begin
							highest_d = first_usable_q;
							if (count_q == '0) begin
								done_d = 1'b1;
								result_d = free_result(first_usable_q);
							end else begin
								rd_en = 1'b1;
								rd_addr = '0;
								state_d = S_FREE_SCAN;
							end
						end
						CMD_CLEAR: begin
							count_d = '0;
							done_d = 1'b1;
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			S_ADD_SCAN: begin
				if (overlap) begin
					done_d = 1'b1;
					result_d.status = STAT_OVERLAP;
					state_d = S_IDLE;
				end else if (scan_last) begin
					wr_en = 1'b1;
					wr_addr = AW'(count_q);
					wr_data = '{start: cmd_q.region_base, size: cmd_q.region_len,
						ptype: cmd_q.region_kind};
					count_d = count_q + CNT_W'(1);
					done_d = 1'b1;
					state_d = S_IDLE;
				end else begin
					rd_en = 1'b1;
					ptr_d = AW'(ptr_plus1);
				end
			end
			S_REM_SHIFT: begin
				// Read data holds the entry one above the slot being filled.
				wr_en = 1'b1;
				wr_addr = ptr_q;
				wr_data = rd_data;
				if (rem_more) begin
					rd_en = 1'b1;
					rd_addr = AW'(ptr_plus2);
					ptr_d = AW'(ptr_plus1);
				end else begin
					count_d = count_q - CNT_W'(1);
					done_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_GET_WAIT: begin
				done_d = 1'b1;
				result_d.entry_start = rd_data.start;
				result_d.entry_size = rd_data.size;
				result_d.entry_type = rd_data.ptype;
				state_d = S_IDLE;
			end
			S_FREE_SCAN: begin
				if (scan_last) begin
					done_d = 1'b1;
					result_d = free_result(max_end);
					state_d = S_IDLE;
				end else begin
					highest_d = max_end;
					rd_en = 1'b1;
					ptr_d = AW'(ptr_plus1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		result_d.entry_count = 5'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q <= 1'b0;
			first_usable_q <= FIRST_USABLE_RESET;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q <= done_d;
			if (cfg_valid) begin
				first_usable_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		cmd_q <= cmd_d;
		highest_q <= highest_d;
		result_q <= result_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign result = result_q;
	assign cfg_ready = 1'b1;

endmodule

/* rtl/drt_checker.sv */
// Port-level checker for the disk region table engine, bound to the top level.
`timescale 1ns / 1ps

module drt_checker
	import drt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input cmd_t cmd,
	input logic done,
	input rsp_t result
);

	// A result is only shown once the engine is ready for the next command.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done raised while busy");

	// No result appears without a command in flight.
	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start) |=> !done)
		else $error("done without an accepted command");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.command == CMD_CLEAR) |=>
		(done && result.status == STAT_OK && result.entry_count == 5'd0))
		else $error("clear did not answer with an empty table");

	// Refused commands return no entry or free-space data.
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != STAT_OK) |->
		(result.entry_start == '0 && result.entry_size == '0 &&
		result.entry_type == '0 && result.free_start == '0 && result.free_size == '0))
		else $error("refused command returned data");

endmodule

bind disk_region_table_engine drt_checker u_drt_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.cmd   (cmd),
	.done  (done),
	.result(result)
);
